[rtl/xml_numeric_entity_codec_assert.svh]
// Assertion macros used by the checker file of the entity codec.
`ifndef XML_NUMERIC_ENTITY_CODEC_ASSERT_SVH
`define XML_NUMERIC_ENTITY_CODEC_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define XNEC_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define XNEC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/xnec_pkg.sv]
`default_nettype none
package xnec_pkg;

    localparam int BurstMax = 5;
    localparam int ByteW    = 8;

    typedef logic [ByteW-1:0] byte_t;

    localparam byte_t CHAR_AMP   = 8'h26;
    localparam byte_t CHAR_APOS  = 8'h27;
    localparam byte_t CHAR_QUOT  = 8'h22;
    localparam byte_t CHAR_GT    = 8'h3E;
    localparam byte_t CHAR_LT    = 8'h3C;
    localparam byte_t CHAR_HASH  = 8'h23;
    localparam byte_t CHAR_SEMI  = 8'h3B;
    localparam byte_t DIGIT_0    = 8'h30;
    localparam byte_t DIGIT_2    = 8'h32;
    localparam byte_t DIGIT_3    = 8'h33;
    localparam byte_t DIGIT_4    = 8'h34;
    localparam byte_t DIGIT_6    = 8'h36;
    localparam byte_t DIGIT_8    = 8'h38;
    localparam byte_t DIGIT_9    = 8'h39;

    typedef enum logic {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        logic [BurstMax-1:0][ByteW-1:0] data;
        logic [2:0]                     count;
        logic                           last;
    } burst_t;

    typedef struct packed {
        logic  hit;
        byte_t d1;
        byte_t d2;
    } ent_t;

    typedef struct packed {
        logic  hit;
        byte_t ch;
    } dec_t;

    function automatic ent_t encode_lookup(input byte_t c);
        ent_t r;
        r = '0;
        unique case (c)
            CHAR_AMP:  r = '{hit: 1'b1, d1: DIGIT_3, d2: DIGIT_8};
            CHAR_APOS: r = '{hit: 1'b1, d1: DIGIT_3, d2: DIGIT_9};
            CHAR_QUOT: r = '{hit: 1'b1, d1: DIGIT_3, d2: DIGIT_4};
            CHAR_GT:   r = '{hit: 1'b1, d1: DIGIT_6, d2: DIGIT_2};
            CHAR_LT:   r = '{hit: 1'b1, d1: DIGIT_6, d2: DIGIT_0};
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic dec_t decode_lookup(input byte_t d1, input byte_t d2);
        dec_t r;
        r = '0;
        unique case ({d1, d2})
            {DIGIT_3, DIGIT_8}: r = '{hit: 1'b1, ch: CHAR_AMP};
            {DIGIT_3, DIGIT_9}: r = '{hit: 1'b1, ch: CHAR_APOS};
            {DIGIT_3, DIGIT_4}: r = '{hit: 1'b1, ch: CHAR_QUOT};
            {DIGIT_6, DIGIT_2}: r = '{hit: 1'b1, ch: CHAR_GT};
            {DIGIT_6, DIGIT_0}: r = '{hit: 1'b1, ch: CHAR_LT};
            default:            r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/xnec_convert.sv]
`default_nettype none
module xnec_convert (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr,
    input  wire logic           cfg_mode,
    input  wire logic           in_take,
    input  wire xnec_pkg::byte_t in_byte,
    input  wire logic           in_last,
    output xnec_pkg::burst_t    burst
);
    import xnec_pkg::*;

    mode_t      mode_reg;
    logic [2:0] ml_reg;
    logic [2:0] ml_next;
    byte_t      held_reg [4];
    logic       held_we;
    logic [1:0] held_idx;

    byte_t      seq [BurstMax];
    ent_t       ent;
    dec_t       dec_full;
    dec_t       dec_tail;
    logic       matched;
    logic       ext_ok;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            seq[i] = (3'(i) < ml_reg) ? held_reg[i] : in_byte;
        end
        seq[4] = in_byte;

        ent      = encode_lookup(in_byte);
        dec_full = decode_lookup(held_reg[2], held_reg[3]);
        dec_tail = decode_lookup(held_reg[2], in_byte);
        matched  = (ml_reg == 3'd4) && (in_byte == CHAR_SEMI) && dec_full.hit;

        unique case (ml_reg)
            3'd0:    ext_ok = (in_byte == CHAR_AMP);
            3'd1:    ext_ok = (in_byte == CHAR_HASH);
            3'd2:    ext_ok = (in_byte == DIGIT_3) || (in_byte == DIGIT_6);
            3'd3:    ext_ok = dec_tail.hit;
            default: ext_ok = 1'b0;
        endcase

        burst.last = in_last;
        for (int i = 0; i < BurstMax; i++) begin
            burst.data[i] = seq[i];
        end
        burst.count = 3'd0;
        ml_next     = 3'd0;
        held_we     = 1'b0;
        held_idx    = ml_reg[1:0];

        if (mode_reg == MODE_ENCODE) begin
            if (ent.hit) begin
                burst.data[0] = CHAR_AMP;
                burst.data[1] = CHAR_HASH;
                burst.data[2] = ent.d1;
                burst.data[3] = ent.d2;
                burst.data[4] = CHAR_SEMI;
                burst.count   = 3'd5;
            end else begin
                burst.data[0] = in_byte;
                burst.count   = 3'd1;
            end
        end else if (matched) begin
            burst.data[0] = dec_full.ch;
            burst.count   = 3'd1;
        end else if (ext_ok) begin
            held_we     = 1'b1;
            burst.count = in_last ? ml_reg + 3'd1 : 3'd0;
            ml_next     = in_last ? 3'd0 : ml_reg + 3'd1;
        end else if (in_byte == CHAR_AMP) begin
            held_we     = 1'b1;
            held_idx    = 2'd0;
            burst.count = in_last ? ml_reg + 3'd1 : ml_reg;
            ml_next     = in_last ? 3'd0 : 3'd1;
        end else begin
            burst.count = ml_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_ENCODE;
            ml_reg   <= 3'd0;
        end else if (cfg_wr) begin
            mode_reg <= mode_t'(cfg_mode);
            ml_reg   <= 3'd0;
        end else if (in_take) begin
            ml_reg <= ml_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take && held_we) begin
            held_reg[held_idx] <= in_byte;
        end
    end

endmodule
`default_nettype wire

[rtl/xnec_emit.sv]
`default_nettype none
module xnec_emit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             take,
    input  wire xnec_pkg::burst_t burst_in,
    output logic                  in_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output xnec_pkg::byte_t       m_data,
    output logic                  m_last
);
    import xnec_pkg::*;

    logic [BurstMax-1:0][ByteW-1:0] buf_reg;
    logic [2:0]                     cnt_reg;
    logic                           last_reg;
    logic                           out_valid_reg;
    byte_t                          out_byte_reg;
    logic                           out_last_reg;
    logic                           out_free;
    logic                           pop;

    assign out_free = !out_valid_reg || m_ready;
    assign pop      = out_free && (cnt_reg != 3'd0);
    assign in_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                cnt_reg <= burst_in.count;
            end else if (pop) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
            if (pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            buf_reg  <= burst_in.data;
            last_reg <= burst_in.last;
        end else if (pop) begin
            buf_reg <= buf_reg >> ByteW;
        end
        if (pop) begin
            out_byte_reg <= buf_reg[0];
            out_last_reg <= last_reg && (cnt_reg == 3'd1);
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_byte_reg;
    assign m_last  = out_last_reg;

endmodule
`default_nettype wire

[rtl/xml_numeric_entity_codec.sv]
// XML numeric entity codec.
// The s_axis channel takes one text byte per item, with tlast on the final byte of a
// string. The m_axis channel returns the converted bytes, with tlast on the final
// output byte of the string. The cfg channel writes the mode bit: 0 encodes the
// characters & ' " > < as &#38; &#39; &#34; &#62; &#60;, 1 decodes those references.
// A mode write drops any partial reference being held; cfg_ready is always high.
// An item produces zero to five output bytes. The first byte is registered in the
// burst buffer and then in the output register before it is valid on m_axis.
// Items that produce at most one byte are taken one per cycle while m_axis is not
// stalled. An item that produces more keeps s_axis_tready low until its burst is
// down to its final byte, as the output register sends at most one byte per cycle.
// A byte that extends a partial reference produces no output until the reference
// completes, fails or the string ends.
// Reset clears the mode to encode and empties all buffers; no clearing pass follows.
// When m_axis_tready is low, the output byte holds and input stops once the
// pending burst is down to its final byte.
`default_nettype none
module xml_numeric_entity_codec (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       cfg_data
);
    import xnec_pkg::*;

    burst_t burst;
    logic   s_take;

    assign cfg_ready = 1'b1;
    assign s_take    = s_axis_tvalid && s_axis_tready;

    xnec_convert u_convert (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_mode (cfg_data),
        .in_take  (s_take),
        .in_byte  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .burst    (burst)
    );

    xnec_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (s_take),
        .burst_in (burst),
        .in_ready (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_data   (m_axis_tdata),
        .m_last   (m_axis_tlast)
    );

endmodule
`default_nettype wire

[rtl/xnec_checker.sv]
`default_nettype none
`include "xml_numeric_entity_codec_assert.svh"
module xnec_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast
);

    `XNEC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `XNEC_ASSERT_NEXT(a_stall_progress, aclk, aresetn, !s_axis_tready && !m_axis_tvalid, m_axis_tvalid)
    `XNEC_ASSERT_IMPL(a_reset_idle, aclk, aresetn, $past(!aresetn), !m_axis_tvalid && s_axis_tready)

endmodule

bind xml_numeric_entity_codec xnec_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xnec_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_ITEMS = 40;
    localparam logic [4:0][7:0] ENT_CHARS = {CHAR_LT, CHAR_GT, CHAR_QUOT, CHAR_APOS, CHAR_AMP};
    localparam logic [4:0][7:0] ENT_D1 = {DIGIT_6, DIGIT_6, DIGIT_3, DIGIT_3, DIGIT_3};
    localparam logic [4:0][7:0] ENT_D2 = {DIGIT_0, DIGIT_2, DIGIT_4, DIGIT_9, DIGIT_8};

    typedef struct packed {
        byte_t ch;
        logic  eos;
        logic  drain_first;
    } text_item_t;

    typedef struct packed {
        byte_t ch;
        logic  eos;
    } out_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;

    text_item_t  pending_text[$];
    out_item_t   expected_out[$];
    mode_t       codec_mode = MODE_ENCODE;
    int          match_len = 0;
    byte_t       held[4];
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          queued_in_phase = 0;
    int          drain_mark = -1;
    int unsigned mismatches = 0;
    int unsigned items_in = 0;
    int unsigned bytes_checked = 0;
    int unsigned entities_done = 0;
    int unsigned cycle_count = 0;

    xml_numeric_entity_codec dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic byte_t entity_byte(input int k, input int pos);
        case (pos)
            0:       return CHAR_AMP;
            1:       return CHAR_HASH;
            2:       return ENT_D1[k];
            3:       return ENT_D2[k];
            default: return CHAR_SEMI;
        endcase
    endfunction

    function automatic int special_index(input byte_t b);
        for (int k = 0; k < 5; k++) begin
            if (ENT_CHARS[k] == b) return k;
        end
        return -1;
    endfunction

    function automatic logic continues_entity(input byte_t b);
        case (match_len)
            0: return b == CHAR_AMP;
            1: return b == CHAR_HASH;
            2: return b == DIGIT_3 || b == DIGIT_6;
            3: begin
                for (int k = 0; k < 5; k++) begin
                    if (held[2] == ENT_D1[k] && b == ENT_D2[k]) return 1'b1;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic emit_byte(input byte_t b);
        expected_out.push_back('{ch: b, eos: 1'b0});
    endtask

    task automatic flush_held();
        for (int i = 0; i < match_len; i++) emit_byte(held[i]);
        match_len = 0;
    endtask

    task automatic convert_byte(input byte_t b, input logic eos);
        int    start;
        int    k;
        logic  hit;
        byte_t dec;
        start = expected_out.size();
        hit = 1'b0;
        dec = '0;
        if (codec_mode == MODE_ENCODE) begin
            match_len = 0;
            k = special_index(b);
            if (k >= 0) begin
                for (int pos = 0; pos < 5; pos++) emit_byte(entity_byte(k, pos));
            end else begin
                emit_byte(b);
            end
        end else begin
            if (match_len == 4 && b == CHAR_SEMI) begin
                for (int j = 0; j < 5; j++) begin
                    if (held[2] == ENT_D1[j] && held[3] == ENT_D2[j]) begin
                        hit = 1'b1;
                        dec = ENT_CHARS[j];
                    end
                end
            end
            if (hit) begin
                match_len = 0;
                entities_done++;
                emit_byte(dec);
            end else if (match_len < 4 && continues_entity(b)) begin
                held[match_len] = b;
                match_len++;
            end else begin
                flush_held();
                if (b == CHAR_AMP) begin
                    held[0] = b;
                    match_len = 1;
                end else begin
                    emit_byte(b);
                end
            end
            if (eos) flush_held();
        end
        if (eos && expected_out.size() > start)
            expected_out[expected_out.size() - 1].eos = 1'b1;
    endtask

    always @(posedge aclk) begin : byte_monitor
        out_item_t want;
        if (!aresetn) begin
            codec_mode = MODE_ENCODE;
            match_len = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                codec_mode = mode_t'(cfg_data);
                match_len = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                convert_byte(s_axis_tdata, s_axis_tlast);
                items_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    report_mismatch($sformatf("output byte 0x%02h with nothing expected",
                        m_axis_tdata));
                end else begin
                    want = expected_out.pop_front();
                    if (m_axis_tdata !== want.ch)
                        report_mismatch($sformatf("byte %0d: data 0x%02h, expected 0x%02h",
                            bytes_checked, m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.eos)
                        report_mismatch($sformatf("byte %0d: tlast %b, expected %b",
                            bytes_checked, m_axis_tlast, want.eos));
                end
                bytes_checked++;
            end
        end
    end

    always @(posedge aclk) begin : text_driver
        text_item_t nxt;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_text.size() > 0 && $urandom_range(99) >= send_idle_pct
                && !(pending_text[0].drain_first && (expected_out.size() > 0
                     || s_axis_tvalid || (m_axis_tvalid && m_axis_tready)))) begin
                nxt = pending_text.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= nxt.ch;
                s_axis_tlast <= nxt.eos;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d bytes still expected",
                cycle_count, expected_out.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_text(input byte_t b, input logic eos);
        pending_text.push_back('{ch: b, eos: eos, drain_first: queued_in_phase == drain_mark});
        queued_in_phase++;
    endtask

    task automatic queue_entity(input int k, input int len);
        for (int pos = 0; pos < len; pos++) queue_text(entity_byte(k, pos), 1'b0);
    endtask

    task automatic fill_encode_text(input int n);
        int k;
        while (queued_in_phase < n) begin
            if ($urandom_range(99) < 30) begin
                k = $urandom_range(4);
                queue_text(ENT_CHARS[k], $urandom_range(9) == 0);
            end else begin
                queue_text(byte_t'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
    endtask

    task automatic fill_decode_text(input int n);
        int pick;
        int k;
        int len;
        while (queued_in_phase < n) begin
            pick = $urandom_range(99);
            k = $urandom_range(4);
            if (pick < 50) begin
                for (int pos = 0; pos < 5; pos++)
                    queue_text(entity_byte(k, pos), $urandom_range(11) == 0);
            end else if (pick < 70) begin
                len = $urandom_range(1, 4);
                for (int pos = 0; pos < len; pos++)
                    queue_text(entity_byte(k, pos), $urandom_range(11) == 0);
                case ($urandom_range(2))
                    0:       queue_text(byte_t'(DIGIT_0 + $urandom_range(9)), 1'b0);
                    1:       queue_text(CHAR_SEMI, $urandom_range(3) == 0);
                    default: queue_text(byte_t'($urandom_range(255)), $urandom_range(3) == 0);
                endcase
            end else if (pick < 80) begin
                queue_text(CHAR_AMP, $urandom_range(5) == 0);
            end else begin
                queue_text(byte_t'($urandom_range(255)), $urandom_range(9) == 0);
            end
        end
        // A partial reference is left open so the next mode write has to drop it.
        queue_entity(3, 3);
    endtask

    task automatic drain_and_settle();
        while (pending_text.size() > 0 || s_axis_tvalid || expected_out.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        queued_in_phase = 0;
    endtask

    task automatic write_mode(input mode_t m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : sequencer
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        queue_text(8'h00, 1'b0);
        queue_text(8'hFF, 1'b0);
        for (int k = 0; k < 5; k++) queue_text(ENT_CHARS[k], k == 4);
        drain_and_settle();

        write_mode(MODE_DECODE);
        // Nested reference: only the outer one is replaced.
        queue_entity(0, 5);
        queue_text(CHAR_HASH, 1'b0);
        queue_text(DIGIT_6, 1'b0);
        queue_text(DIGIT_0, 1'b0);
        queue_text(CHAR_SEMI, 1'b0);
        queue_entity(1, 5);
        queue_text(CHAR_AMP, 1'b0);
        queue_entity(2, 4);
        queue_text(8'h78, 1'b0);
        queue_entity(3, 3);
        queue_text(ENT_D2[3], 1'b1);
        queue_entity(4, 3);
        drain_and_settle();

        for (int p = 0; p < 8; p++) begin
            case (p / 2)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            drain_mark = PHASE_ITEMS / 2;
            if (p % 2 == 0) begin
                write_mode(MODE_DECODE);
                fill_decode_text(PHASE_ITEMS);
            end else begin
                write_mode(MODE_ENCODE);
                fill_encode_text(PHASE_ITEMS);
            end
            drain_and_settle();
        end

        $display("Sent %0d text bytes in both modes under four idling patterns;", items_in);
        $display("checked %0d output bytes, %0d references decoded.",
            bytes_checked, entities_done);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/xnec_pkg.sv
rtl/xnec_convert.sv
rtl/xnec_emit.sv
rtl/xml_numeric_entity_codec.sv
rtl/xnec_checker.sv
sim/testbench.sv
